>>> rtl/cbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_TOUCH_LOCKOUT   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOCK_PULSE_LEN  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_FADE_MAX        = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAINS_THRESHOLD = 8'd3;
  localparam int unsigned CfgDataW = 16;

  // register reset values
  localparam logic [15:0] TOUCH_LOCKOUT_RST   = 16'd100;
  localparam logic [15:0] LOCK_PULSE_LEN_RST  = 16'd100;
  localparam logic [7:0]  FADE_MAX_RST        = 8'd128;
  localparam logic [9:0]  MAINS_THRESHOLD_RST = 10'd200;

  // switch latch bit positions
  localparam int unsigned SW_RADIO  = 0;
  localparam int unsigned SW_COOLER = 1;
  localparam int unsigned SW_LIGHT  = 2;
  localparam int unsigned SW_RAIL   = 3;
  localparam int unsigned SW_MISC   = 4;
  localparam int unsigned SW_LOCK   = 5;

  localparam logic [15:0] PULSE_TOP = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_UNLOCK = 2'd1,
    ACT_LOCK   = 2'd2
  } pulse_act_e;

  typedef struct packed {
    logic [15:0] touch_lockout;
    logic [15:0] lock_pulse_len;
    logic [7:0]  fade_max;
    logic [9:0]  mains_threshold;
  } cfg_t;

  typedef struct packed {
    logic       door_sense_n;
    logic       locked_sense_n;
    logic [9:0] mains_sample;
    logic [5:0] touch_keys;
  } in_item_t;

  typedef struct packed {
    logic       rail_5v_on;
    logic       cooler_on;
    logic       radio_on;
    logic       mains_present;
    logic       lock_drive;
    logic       unlock_drive;
    logic [7:0] white_level;
    logic [7:0] panel_leds;
    logic       panel_update;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/cbt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cbt_cfg_regs
  import cbt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [CfgIdxW-1:0]  idx_i,
  input  wire logic [CfgDataW-1:0] data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_TOUCH_LOCKOUT:   cfg_d.touch_lockout   = data_i;
        CFG_LOCK_PULSE_LEN:  cfg_d.lock_pulse_len  = data_i;
        CFG_FADE_MAX:        cfg_d.fade_max        = data_i[7:0];
        CFG_MAINS_THRESHOLD: cfg_d.mains_threshold = data_i[9:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_lockout   <= TOUCH_LOCKOUT_RST;
      cfg_q.lock_pulse_len  <= LOCK_PULSE_LEN_RST;
      cfg_q.fade_max        <= FADE_MAX_RST;
      cfg_q.mains_threshold <= MAINS_THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/cbt_core.sv
`timescale 1ns / 1ps
`default_nettype none

module cbt_core
  import cbt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  input  wire cfg_t      cfg_i,
  output out_item_t      res_o
);

  logic [5:0]  sw_q, sw_d;
  logic [15:0] lockout_q, lockout_d;
  logic [7:0]  fade_q, fade_d;
  logic [15:0] pulse_q, pulse_d;
  pulse_act_e  act_q, act_d;
  logic        lock_pin_q, lock_pin_d;
  logic        unlock_pin_q, unlock_pin_d;
  logic [7:0]  last_panel_q, last_panel_d;

  logic        door_ajar, locked, light_req;
  logic [15:0] lockout_dec;
  logic [5:0]  sw_t;
  logic [7:0]  panel;

  always_comb begin
    door_ajar = ~item_i.door_sense_n;
    locked    = ~item_i.locked_sense_n;

    lockout_dec = (lockout_q != 16'd0) ? lockout_q - 16'd1 : 16'd0;
    pulse_d     = (pulse_q != PULSE_TOP) ? pulse_q + 16'd1 : pulse_q;
    act_d       = act_q;

    // touch accept and lockout reload
    if (lockout_dec == 16'd0 && item_i.touch_keys != 6'd0) begin
      lockout_d = cfg_i.touch_lockout;
      sw_t      = sw_q ^ item_i.touch_keys;
    end else begin
      lockout_d = lockout_dec;
      sw_t      = sw_q;
    end

    // lock key is a one-shot: start the pulse and drop the latch
    sw_d = sw_t;
    if (sw_t[SW_LOCK]) begin
      act_d         = locked ? ACT_UNLOCK : ACT_LOCK;
      pulse_d       = 16'd0;
      sw_d[SW_LOCK] = 1'b0;
    end

    light_req = door_ajar | sw_d[SW_LIGHT];
    fade_d = fade_q;
    if (light_req) begin
      if (fade_q < cfg_i.fade_max) fade_d = fade_q + 8'd1;
    end else if (fade_q != 8'd0) begin
      fade_d = fade_q - 8'd1;
    end

    lock_pin_d   = lock_pin_q;
    unlock_pin_d = unlock_pin_q;
    priority if (pulse_d == 16'd0) begin
      if (act_d == ACT_UNLOCK) unlock_pin_d = 1'b1;
      else if (act_d == ACT_LOCK) lock_pin_d = 1'b1;
    end else if (pulse_d == cfg_i.lock_pulse_len) begin
      lock_pin_d   = 1'b0;
      unlock_pin_d = 1'b0;
    end else if (pulse_d > cfg_i.lock_pulse_len) begin
      pulse_d = 16'd1;
    end

    panel = {locked, sw_d[SW_MISC], sw_d[SW_RAIL], light_req,
             sw_d[SW_COOLER], sw_d[SW_RADIO], 2'b00};
    last_panel_d = panel;

    res_o.rail_5v_on    = sw_d[SW_RAIL];
    res_o.cooler_on     = sw_d[SW_COOLER];
    res_o.radio_on      = sw_d[SW_RADIO];
    res_o.mains_present = ({6'd0, item_i.mains_sample} < {6'd0, cfg_i.mains_threshold});
    res_o.lock_drive    = lock_pin_d;
    res_o.unlock_drive  = unlock_pin_d;
    res_o.white_level   = fade_d;
    res_o.panel_leds    = panel;
    res_o.panel_update  = (panel != last_panel_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q         <= '0;
      lockout_q    <= '0;
      fade_q       <= '0;
      pulse_q      <= 16'd1;
      act_q        <= ACT_NONE;
      lock_pin_q   <= 1'b0;
      unlock_pin_q <= 1'b0;
      last_panel_q <= '0;
    end else if (step_i) begin
      sw_q         <= sw_d;
      lockout_q    <= lockout_d;
      fade_q       <= fade_d;
      pulse_q      <= pulse_d;
      act_q        <= act_d;
      lock_pin_q   <= lock_pin_d;
      unlock_pin_q <= unlock_pin_d;
      last_panel_q <= last_panel_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/car_body_touch_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Car body touch controller: one input transfer per control tick.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): sense pins, mains sample
// and touch keys of one tick. Output channel (out_valid_o / out_stall_i /
// out_item_o): switch states, drive levels, fade level and panel word of that tick.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): always
// ready; indexes 0..3 select touch_lockout, lock_pulse_len, fade_max and
// mains_threshold, other indexes are dropped. Write only while the block is idle.
//
// Path: an input transfer is captured in the input register, then the tick logic
// feeds the result register, whose valid flag drives out_valid_o. Throughput: one
// tick per cycle while out_stall_i is low; the single-tick state update between the
// two registers sets that figure.
//
// Reset: registers take their reset values, all latches, counters and drives
// clear (pulse counter to one), both stages empty.
// Stall: a stalled result holds in the output register; the input register still
// takes one more tick, after which in_stall_o rises until the result drains.

module car_body_touch_controller
  import cbt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire in_item_t            in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t res, out_q;
  logic      out_valid_q;
  logic      out_free, step, in_take;

  assign cfg_ready_o = 1'b1;

  cbt_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // output register frees when empty or when its result transfers this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  // tick is processed (state advanced) as it moves into the output register
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  cbt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_item_i;
    if (step) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
